[rtl/core/elbp_pkg.sv]
// elbp_pkg: shared types and constants for the escape and literal byte parser
// command word passed from the front to the back through the queue
// no dependencies
package elbp_pkg;

	localparam int MAX_EOL_BYTES = 4;
	localparam int FIFO_DEPTH    = 2;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int EOL_CNT_W     = 3;
	localparam int ACC_W         = 10;
	localparam int DIG_W         = 4;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_RAW  = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_OFF  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PARSE_MODE = 2'd0,
		REG_EOL_COUNT  = 2'd1,
		REG_EOL_WORD   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_BSL      = 4'd1,
		PH_XFIRST   = 4'd2,
		PH_XSECOND  = 4'd3,
		PH_OCT      = 4'd4,
		PH_DEC      = 4'd5,
		PH_ZERO     = 4'd6,
		PH_BINFIRST = 4'd7,
		PH_BIN      = 4'd8
	} phase_t;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BANG  = 8'd33;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [7:0] ESC_BEL = 8'd7;
	localparam logic [7:0] ESC_BS  = 8'd8;
	localparam logic [7:0] ESC_ESC = 8'd27;
	localparam logic [7:0] ESC_FF  = 8'd12;
	localparam logic [7:0] ESC_LF  = 8'd10;
	localparam logic [7:0] ESC_CR  = 8'd13;
	localparam logic [7:0] ESC_TAB = 8'd9;
	localparam logic [7:0] ESC_VT  = 8'd11;

	localparam logic [ACC_W-1:0] BYTE_LIMIT = 10'd256;
	localparam logic [EOL_CNT_W-1:0] EOL_COUNT_RST = 3'd1;
	localparam logic [CFG_W-1:0] EOL_WORD_RST = 32'd10;

	// one accepted item's worth of output
	typedef struct packed {
		logic                 is_line;
		logic                 b0_v;
		logic                 b0_has;
		logic [7:0]           b0;
		logic                 b1_v;
		logic [7:0]           b1;
		logic [EOL_CNT_W-1:0] eol_n;
		logic [CFG_W-1:0]     eol_word;
	} cmd_t;

	typedef struct packed {
		logic             emit;
		logic [7:0]       data;
		phase_t           phase;
		logic [ACC_W-1:0] acc;
		logic [DIG_W-1:0] dig;
		logic             again;
	} step_t;

endpackage

[rtl/core/escape_and_literal_byte_parser.sv]
// escape_and_literal_byte_parser: top level of the text to byte parser
// front decode, command queue and result expansion; depends on elbp_pkg,
// elbp_front, elbp_fifo, elbp_back
//
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata[7:0] char_code, s_tlast line_end
// m_       | out | m_tvalid/m_tready  | m_tdata[7:0] data_byte, m_tuser[0] has_byte,
//          |     |                    | m_tlast line_done
// cfg_     | in  | cfg_we             | cfg_index, cfg_wdata
//
// a character is taken every cycle while the queue has room; results leave one per cycle
// while the output is not stalled, set by the single output register draining the queue
// a character gives up to two results, a line end up to 1 + MAX_EOL_BYTES
// reset clears mode to text, eol_count to 1, eol_word to 10 and the token state
// a stalled output holds its word while the front keeps taking input until the queue fills
module escape_and_literal_byte_parser #(
	parameter int MAX_EOL_BYTES = elbp_pkg::MAX_EOL_BYTES,
	parameter int FIFO_DEPTH    = elbp_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // char_code
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // data_byte
	output logic [0:0]                      m_tuser,   // has_byte
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [elbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [elbp_pkg::CFG_W-1:0]      cfg_wdata
);

	logic           push, pop, q_full, head_valid;
	elbp_pkg::cmd_t push_cmd, head;

	elbp_front #(
		.MAX_EOL_BYTES (MAX_EOL_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.char_code (s_tdata),
		.line_end  (s_tlast),
		.in_ready  (s_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	elbp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	elbp_back #(
		.MAX_EOL_BYTES (MAX_EOL_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

[rtl/core/elbp_front.sv]
// elbp_front: configuration registers, token state and character decode
// produces at most one command per item for the queue; depends on elbp_pkg
module elbp_front #(
	parameter int MAX_EOL_BYTES = elbp_pkg::MAX_EOL_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [7:0]                          char_code,
	input  logic                                line_end,
	output logic                                in_ready,
	input  logic                                cfg_we,
	input  logic [elbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [elbp_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                q_full,
	output logic                                push,
	output elbp_pkg::cmd_t                      push_cmd
);

	elbp_pkg::mode_t                     mode_q;
	logic [elbp_pkg::EOL_CNT_W-1:0]      eol_count_q;
	logic [elbp_pkg::CFG_W-1:0]          eol_word_q;
	elbp_pkg::phase_t                    phase_q;
	logic [elbp_pkg::ACC_W-1:0]          acc_q;
	logic [elbp_pkg::DIG_W-1:0]          dig_q;

	elbp_pkg::step_t                     st1, st2, st_nx;
	elbp_pkg::cmd_t                      cmd;
	logic                                accept;

	function automatic logic [4:0] hexval(logic [7:0] c);
		logic [4:0] h;
		h = 5'd0;
		if (c >= elbp_pkg::CH_0 && c <= elbp_pkg::CH_9)
			h = {1'b1, 4'(c - elbp_pkg::CH_0)};
		else if (c >= elbp_pkg::CH_UA && c <= elbp_pkg::CH_UF)
			h = {1'b1, 4'(c - elbp_pkg::CH_UA + 8'd10)};
		else if (c >= elbp_pkg::CH_LA && c <= elbp_pkg::CH_LF)
			h = {1'b1, 4'(c - elbp_pkg::CH_LA + 8'd10)};
		return h;
	endfunction

	function automatic elbp_pkg::step_t idle_step(elbp_pkg::mode_t mode, logic [7:0] c);
		elbp_pkg::step_t s;
		logic [4:0]      h;
		s = '{emit: 1'b0, data: 8'd0, phase: elbp_pkg::PH_IDLE, acc: '0, dig: '0,
			again: 1'b0};
		h = hexval(c);
		case (mode)
			elbp_pkg::MODE_TEXT: begin
				if (c >= elbp_pkg::CH_SPACE && c <= elbp_pkg::CH_TILDE) begin
					if (c == elbp_pkg::CH_BSL) s.phase = elbp_pkg::PH_BSL;
					else begin
						s.emit = 1'b1;
						s.data = c;
					end
				end
			end
			elbp_pkg::MODE_RAW: begin
				if (c >= elbp_pkg::CH_BANG && c <= elbp_pkg::CH_TILDE) begin
					if (c == elbp_pkg::CH_0) s.phase = elbp_pkg::PH_ZERO;
					else if (c >= elbp_pkg::CH_1 && c <= elbp_pkg::CH_9) begin
						s.phase = elbp_pkg::PH_DEC;
						s.acc   = 10'(c - elbp_pkg::CH_0);
						s.dig   = 4'd1;
					end else begin
						s.emit = 1'b1;
						s.data = c;
					end
				end
			end
			elbp_pkg::MODE_HEX: begin
				if (c >= elbp_pkg::CH_BANG && c <= elbp_pkg::CH_TILDE && h[4]) begin
					s.phase = elbp_pkg::PH_XSECOND;
					s.acc   = 10'(h[3:0]);
					s.dig   = 4'd1;
				end
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic elbp_pkg::step_t char_step(elbp_pkg::mode_t mode,
		elbp_pkg::phase_t ph, logic [elbp_pkg::ACC_W-1:0] acc,
		logic [elbp_pkg::DIG_W-1:0] dig, logic [7:0] c);
		elbp_pkg::step_t             s;
		logic [4:0]                  h;
		logic [7:0]                  d;
		logic [3:0]                  base;
		logic [3:0]                  limit;
		logic [elbp_pkg::ACC_W-1:0]  acc_mul;
		logic [elbp_pkg::ACC_W-1:0]  acc_n;
		logic [elbp_pkg::DIG_W-1:0]  dig_n;
		s = '{emit: 1'b0, data: 8'd0, phase: elbp_pkg::PH_IDLE, acc: '0, dig: '0,
			again: 1'b0};
		h = hexval(c);
		d = c - elbp_pkg::CH_0;
		case (ph)
			elbp_pkg::PH_OCT: begin
				base = 4'd8;
				limit = 4'd3;
				acc_mul = {acc[6:0], 3'b000};
			end
			elbp_pkg::PH_DEC: begin
				base = 4'd10;
				limit = 4'd3;
				acc_mul = 10'({acc[6:0], 3'b000} + {acc[8:0], 1'b0});
			end
			default: begin
				base = 4'd2;
				limit = 4'd8;
				acc_mul = {acc[8:0], 1'b0};
			end
		endcase
		acc_n = 10'(acc_mul + 10'(d));
		dig_n = 4'(dig + 4'd1);
		case (ph)
			elbp_pkg::PH_IDLE: s = idle_step(mode, c);
			elbp_pkg::PH_BSL: begin
				if (c >= elbp_pkg::CH_0 && c <= elbp_pkg::CH_7) begin
					s.phase = elbp_pkg::PH_OCT;
					s.acc   = 10'(d);
					s.dig   = 4'd1;
				end else begin
					s.emit = 1'b1;
					case (c)
						elbp_pkg::CH_LA: s.data = elbp_pkg::ESC_BEL;
						elbp_pkg::CH_LB: s.data = elbp_pkg::ESC_BS;
						elbp_pkg::CH_LE: s.data = elbp_pkg::ESC_ESC;
						elbp_pkg::CH_LF: s.data = elbp_pkg::ESC_FF;
						elbp_pkg::CH_LN: s.data = elbp_pkg::ESC_LF;
						elbp_pkg::CH_LR: s.data = elbp_pkg::ESC_CR;
						elbp_pkg::CH_LT: s.data = elbp_pkg::ESC_TAB;
						elbp_pkg::CH_LV: s.data = elbp_pkg::ESC_VT;
						elbp_pkg::CH_LX: begin
							s.emit  = 1'b0;
							s.phase = elbp_pkg::PH_XFIRST;
						end
						default: begin
							s.emit = (c >= elbp_pkg::CH_SPACE && c <= elbp_pkg::CH_TILDE);
							s.data = c;
						end
					endcase
				end
			end
			elbp_pkg::PH_XFIRST: begin
				if (h[4]) begin
					s.phase = elbp_pkg::PH_XSECOND;
					s.acc   = 10'(h[3:0]);
					s.dig   = 4'd1;
				end
			end
			elbp_pkg::PH_XSECOND: begin
				s.emit = 1'b1;
				if (h[4]) s.data = {acc[3:0], h[3:0]};
				else begin
					s.data  = acc[7:0];
					s.again = 1'b1;
				end
			end
			elbp_pkg::PH_OCT, elbp_pkg::PH_DEC, elbp_pkg::PH_BIN: begin
				if (c >= elbp_pkg::CH_0 && d < 8'(base)) begin
					if (dig_n >= limit) begin
						s.emit = (acc_n < elbp_pkg::BYTE_LIMIT);
						s.data = acc_n[7:0];
					end else begin
						s.phase = ph;
						s.acc   = acc_n;
						s.dig   = dig_n;
					end
				end else begin
					s.emit  = (acc < elbp_pkg::BYTE_LIMIT);
					s.data  = acc[7:0];
					s.again = 1'b1;
				end
			end
			elbp_pkg::PH_ZERO: begin
				if (c == elbp_pkg::CH_LX || c == elbp_pkg::CH_UX)
					s.phase = elbp_pkg::PH_XFIRST;
				else if (c == elbp_pkg::CH_LB || c == elbp_pkg::CH_UB)
					s.phase = elbp_pkg::PH_BINFIRST;
				else if (c >= elbp_pkg::CH_0 && c <= elbp_pkg::CH_7) begin
					s.phase = elbp_pkg::PH_OCT;
					s.acc   = 10'(d);
					s.dig   = 4'd1;
				end else begin
					s.emit  = 1'b1;
					s.data  = 8'd0;
					s.again = 1'b1;
				end
			end
			elbp_pkg::PH_BINFIRST: begin
				if (c == elbp_pkg::CH_0 || c == elbp_pkg::CH_1) begin
					s.phase = elbp_pkg::PH_BIN;
					s.acc   = 10'(d);
					s.dig   = 4'd1;
				end
			end
			default: s.again = 1'b1;
		endcase
		return s;
	endfunction

	always_comb begin
		st1 = char_step(mode_q, phase_q, acc_q, dig_q, char_code);
		st2 = idle_step(mode_q, char_code);
		st_nx = st1.again ? st2 : st1;

		cmd = '0;
		cmd.eol_word = eol_word_q;
		if (line_end) begin
			cmd.is_line = 1'b1;
			cmd.b0_has  = 1'b1;
			case (phase_q)
				elbp_pkg::PH_XSECOND, elbp_pkg::PH_OCT, elbp_pkg::PH_DEC,
				elbp_pkg::PH_BIN: begin
					cmd.b0_v = (acc_q < elbp_pkg::BYTE_LIMIT);
					cmd.b0   = acc_q[7:0];
				end
				elbp_pkg::PH_ZERO: cmd.b0_v = 1'b1;
				default: ;
			endcase
			if (mode_q == elbp_pkg::MODE_TEXT) begin
				if (int'(eol_count_q) > MAX_EOL_BYTES)
					cmd.eol_n = elbp_pkg::EOL_CNT_W'(MAX_EOL_BYTES);
				else
					cmd.eol_n = eol_count_q;
			end
			// bare marker when the line yields nothing
			if (!cmd.b0_v && cmd.eol_n == '0) begin
				cmd.b0_v   = 1'b1;
				cmd.b0_has = 1'b0;
				cmd.b0     = 8'd0;
			end
		end else begin
			cmd.b0_has = 1'b1;
			cmd.b0_v   = st1.emit;
			cmd.b0     = st1.data;
			cmd.b1_v   = st1.again && st2.emit;
			cmd.b1     = st2.data;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cmd.is_line || cmd.b0_v || cmd.b1_v);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= elbp_pkg::MODE_TEXT;
			eol_count_q <= elbp_pkg::EOL_COUNT_RST;
			eol_word_q  <= elbp_pkg::EOL_WORD_RST;
			phase_q     <= elbp_pkg::PH_IDLE;
			acc_q       <= '0;
			dig_q       <= '0;
		end else if (cfg_we) begin
			case (elbp_pkg::reg_idx_t'(cfg_index))
				elbp_pkg::REG_PARSE_MODE: begin
					mode_q  <= elbp_pkg::mode_t'(cfg_wdata[1:0]);
					phase_q <= elbp_pkg::PH_IDLE;
					acc_q   <= '0;
					dig_q   <= '0;
				end
				elbp_pkg::REG_EOL_COUNT: eol_count_q <= cfg_wdata[elbp_pkg::EOL_CNT_W-1:0];
				elbp_pkg::REG_EOL_WORD:  eol_word_q <= cfg_wdata;
				default: ;
			endcase
		end else if (accept) begin
			if (line_end) begin
				phase_q <= elbp_pkg::PH_IDLE;
				acc_q   <= '0;
				dig_q   <= '0;
			end else begin
				phase_q <= st_nx.phase;
				acc_q   <= st_nx.acc;
				dig_q   <= st_nx.dig;
			end
		end
	end

endmodule

[rtl/core/elbp_fifo.sv]
// elbp_fifo: short command queue between the front and the back
// depends on elbp_pkg for the command word
module elbp_fifo #(
	parameter int DEPTH = elbp_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  elbp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output elbp_pkg::cmd_t head,
	output logic           head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	elbp_pkg::cmd_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop) count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push) count_q <= CNT_W'(count_q - 1'b1);
		end
	end

endmodule

[rtl/core/elbp_back.sv]
// elbp_back: expands queued commands into result words, one per cycle while not stalled
// output register toward the master side; depends on elbp_pkg
module elbp_back #(
	parameter int MAX_EOL_BYTES = elbp_pkg::MAX_EOL_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  elbp_pkg::cmd_t head,
	input  logic           head_valid,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic [0:0]     m_tuser,
	output logic           m_tlast
);

	localparam int NSLOT = 2 + MAX_EOL_BYTES;
	localparam int IDX_W = $clog2(NSLOT);
	localparam int EXT_W = 8 * ((MAX_EOL_BYTES > 4) ? MAX_EOL_BYTES : 4);

	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  sel;
	logic              found, more;
	logic [NSLOT-1:0]  slot_v;
	logic [7:0]        slot_b [NSLOT];
	logic [EXT_W-1:0]  eol_ext;
	logic              issue;
	logic              has_b;

	always_comb begin
		eol_ext = EXT_W'(head.eol_word);
		slot_v[0] = head.b0_v;
		slot_b[0] = head.b0;
		slot_v[1] = head.b1_v;
		slot_b[1] = head.b1;
		for (int k = 0; k < MAX_EOL_BYTES; k++) begin
			slot_v[2+k] = (k < int'(head.eol_n));
			slot_b[2+k] = eol_ext[8*k +: 8];
		end
		found = 1'b0;
		more  = 1'b0;
		sel   = '0;
		for (int k = 0; k < NSLOT; k++) begin
			if (slot_v[k] && IDX_W'(k) >= idx_q) begin
				if (!found) begin
					found = 1'b1;
					sel   = IDX_W'(k);
				end else more = 1'b1;
			end
		end
		has_b = (sel == '0) ? head.b0_has : 1'b1;
	end

	assign issue = head_valid && found && (!m_tvalid || m_tready);
	assign pop   = issue && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (issue) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (issue) idx_q <= more ? IDX_W'(sel + 1'b1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_tdata    <= slot_b[sel];
			m_tuser[0] <= has_b;
			m_tlast    <= head.is_line && !more;
		end
	end

	a_cmd_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> found)
		else $error("queued command has no result left");

	a_mid_cmd_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> head_valid)
		else $error("command expansion lost its head");

	a_marker_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
		else $error("bare marker not closing a line");

endmodule

[sim/escape_and_literal_byte_parser_tb.sv]
// escape_and_literal_byte_parser_tb: self-checking bench for the text to byte parser
// sends lines in every parse mode through bursty input and a stalling output, and checks
// each output word against a decoder kept in the bench; depends on elbp_pkg and the rtl
module escape_and_literal_byte_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import elbp_pkg::*;

	localparam int SETTLE       = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 120;
	localparam int MAX_PRINTS   = 50;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} out_word_t;

	class decoded_byte_checker;
		mode_t                mode;
		logic [EOL_CNT_W-1:0] eol_n;
		logic [CFG_W-1:0]     eol_w;
		phase_t               ph;
		logic [ACC_W-1:0]     acc;
		logic [DIG_W-1:0]     ndig;
		out_word_t            awaited_bytes[$];
		int                   mismatch_count;

		function new();
			mode = MODE_TEXT;
			eol_n = EOL_COUNT_RST;
			eol_w = EOL_WORD_RST;
			mismatch_count = 0;
			go_idle();
		endfunction

		function void go_idle();
			ph = PH_IDLE;
			acc = '0;
			ndig = '0;
		endfunction

		function void push_byte(logic [7:0] b, logic has);
			out_word_t w;
			w.data = b;
			w.has = has;
			w.last = 1'b0;
			awaited_bytes.push_back(w);
		endfunction

		function void open_run(phase_t p, logic [ACC_W-1:0] v);
			ph = p;
			acc = v;
			ndig = 1;
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= CH_0 && c <= CH_9)
				return int'(c - CH_0);
			if (c >= CH_UA && c <= CH_UF)
				return int'(c - CH_UA) + 10;
			if (c >= CH_LA && c <= CH_LF)
				return int'(c - CH_LA) + 10;
			return -1;
		endfunction

		// returns 1 when the ending character has to be decoded again
		function bit digit_run(logic [7:0] c, int base, int lim);
			int d;
			d = int'(c) - int'(CH_0);
			if (d >= 0 && d < base) begin
				acc = ACC_W'(int'(acc) * base + d);
				ndig = ndig + 1'b1;
				if (int'(ndig) >= lim) begin
					if (acc < BYTE_LIMIT)
						push_byte(acc[7:0], 1'b1);
					go_idle();
				end
				return 1'b0;
			end
			if (acc < BYTE_LIMIT)
				push_byte(acc[7:0], 1'b1);
			go_idle();
			return 1'b1;
		endfunction

		function void idle_char(logic [7:0] c);
			int h;
			case (mode)
				MODE_TEXT: begin
					if (c >= CH_SPACE && c <= CH_TILDE) begin
						if (c == CH_BSL)
							ph = PH_BSL;
						else
							push_byte(c, 1'b1);
					end
				end
				MODE_RAW: begin
					if (c >= CH_BANG && c <= CH_TILDE) begin
						if (c == CH_0)
							ph = PH_ZERO;
						else if (c >= CH_1 && c <= CH_9)
							open_run(PH_DEC, ACC_W'(c - CH_0));
						else
							push_byte(c, 1'b1);
					end
				end
				MODE_HEX: begin
					if (c >= CH_BANG && c <= CH_TILDE) begin
						h = hex_digit(c);
						if (h >= 0)
							open_run(PH_XSECOND, ACC_W'(h));
					end
				end
				default: ;
			endcase
		endfunction

		function bit decode_char(logic [7:0] c);
			int h;
			case (ph)
				PH_IDLE: idle_char(c);
				PH_BSL: begin
					go_idle();
					if (c >= CH_0 && c <= CH_7) begin
						open_run(PH_OCT, ACC_W'(c - CH_0));
					end else begin
						case (c)
							CH_LA: push_byte(ESC_BEL, 1'b1);
							CH_LB: push_byte(ESC_BS, 1'b1);
							CH_LE: push_byte(ESC_ESC, 1'b1);
							CH_LF: push_byte(ESC_FF, 1'b1);
							CH_LN: push_byte(ESC_LF, 1'b1);
							CH_LR: push_byte(ESC_CR, 1'b1);
							CH_LT: push_byte(ESC_TAB, 1'b1);
							CH_LV: push_byte(ESC_VT, 1'b1);
							CH_LX: ph = PH_XFIRST;
							default: begin
								if (c >= CH_SPACE && c <= CH_TILDE)
									push_byte(c, 1'b1);
							end
						endcase
					end
				end
				PH_XFIRST: begin
					h = hex_digit(c);
					go_idle();
					if (h >= 0)
						open_run(PH_XSECOND, ACC_W'(h));
				end
				PH_XSECOND: begin
					h = hex_digit(c);
					if (h >= 0) begin
						push_byte({acc[3:0], 4'(h)}, 1'b1);
						go_idle();
					end else begin
						push_byte(acc[7:0], 1'b1);
						go_idle();
						return 1'b1;
					end
				end
				PH_OCT: return digit_run(c, 8, 3);
				PH_DEC: return digit_run(c, 10, 3);
				PH_BIN: return digit_run(c, 2, 8);
				PH_ZERO: begin
					go_idle();
					if (c == CH_LX || c == CH_UX) begin
						ph = PH_XFIRST;
					end else if (c == CH_LB || c == CH_UB) begin
						ph = PH_BINFIRST;
					end else if (c >= CH_0 && c <= CH_7) begin
						open_run(PH_OCT, ACC_W'(c - CH_0));
					end else begin
						push_byte(8'd0, 1'b1);
						return 1'b1;
					end
				end
				PH_BINFIRST: begin
					go_idle();
					if (c == CH_0 || c == CH_1)
						open_run(PH_BIN, ACC_W'(c - CH_0));
				end
				default: begin
					go_idle();
					return 1'b1;
				end
			endcase
			return 1'b0;
		endfunction

		function void note_word(logic [7:0] c, logic line_end);
			int start;
			int n;
			out_word_t w;
			start = awaited_bytes.size();
			if (line_end) begin
				case (ph)
					PH_XSECOND, PH_OCT, PH_DEC, PH_BIN: begin
						if (acc < BYTE_LIMIT)
							push_byte(acc[7:0], 1'b1);
					end
					PH_ZERO: push_byte(8'd0, 1'b1);
					default: ;
				endcase
				go_idle();
				if (mode == MODE_TEXT) begin
					n = (eol_n > MAX_EOL_BYTES) ? MAX_EOL_BYTES : int'(eol_n);
					for (int i = 0; i < n; i++)
						push_byte(eol_w[8*i +: 8], 1'b1);
				end
				if (awaited_bytes.size() == start)
					push_byte(8'd0, 1'b0);
				w = awaited_bytes.pop_back();
				w.last = 1'b1;
				awaited_bytes.push_back(w);
			end else if (decode_char(c)) begin
				void'(decode_char(c));
			end
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PARSE_MODE: begin
					mode = mode_t'(val[1:0]);
					go_idle();
				end
				REG_EOL_COUNT: eol_n = val[EOL_CNT_W-1:0];
				REG_EOL_WORD:  eol_w = val;
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, out_word_t got, out_word_t want);
			mismatch_count++;
			if (mismatch_count <= MAX_PRINTS)
				$display("%0t %s: got %02h/%0b/%0b want %02h/%0b/%0b", $realtime, what,
					got.data, got.has, got.last, want.data, want.has, want.last);
		endtask

		task check_word(out_word_t got);
			out_word_t want;
			if (awaited_bytes.size() == 0) begin
				report_mismatch("unexpected word", got, '0);
				return;
			end
			want = awaited_bytes.pop_front();
			if (got.data !== want.data || got.has !== want.has || got.last !== want.last)
				report_mismatch("wrong word", got, want);
		endtask

		function int waiting();
			return awaited_bytes.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	decoded_byte_checker decoded;
	logic [7:0] line_q[$];
	int         burst_left = 0;
	int         items_sent = 0;
	mode_t      cur_mode = MODE_TEXT;
	int         cycle_count = 0;
	int         rx_tick = 0;
	int         rx_style = 0;

	escape_and_literal_byte_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // char_code
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // data_byte
		.m_tuser   (m_tuser),   // has_byte
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				decoded.check_word({m_tdata, m_tuser[0], m_tlast});
			if (s_tvalid && s_tready)
				decoded.note_word(s_tdata, s_tlast);
		end
	end

	// receiver stall pattern, with a style picked at random
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 50 == 0)
			rx_style = $urandom_range(0, 3);
		case (rx_style)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_tick % 4 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task send_char(logic [7:0] c, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cur_mode != MODE_OFF)
			items_sent++;
	endtask

	task send_line(bit with_end);
		foreach (line_q[i])
			send_char(line_q[i], 1'b0);
		if (with_end)
			send_char(8'($urandom), 1'b1);
		line_q.delete();
	endtask

	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded.waiting() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		decoded.apply_write(idx, val);
		if (idx == REG_PARSE_MODE)
			cur_mode = mode_t'(val[1:0]);
	endtask

	task set_config(mode_t m, logic [EOL_CNT_W-1:0] n, logic [CFG_W-1:0] w);
		write_reg(REG_PARSE_MODE, CFG_W'(m));
		write_reg(REG_EOL_COUNT, CFG_W'(n));
		write_reg(REG_EOL_WORD, w);
		cfg_we <= 1'b0;
	endtask

	task queue_text(string s);
		foreach (s[i])
			line_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] hex_char();
		string digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	task automatic add_token(mode_t m);
		int k;
		logic [7:0] c;
		string esc = "abefnrtv";
		k = $urandom_range(0, 9);
		case (m)
			MODE_TEXT: begin
				case (k)
					0, 1, 2: begin
						do c = 8'($urandom_range(32, 126)); while (c == CH_BSL);
						line_q.push_back(c);
					end
					3: begin
						line_q.push_back(CH_BSL);
						line_q.push_back(esc[$urandom_range(0, 7)]);
					end
					4: begin
						line_q.push_back(CH_BSL);
						repeat ($urandom_range(1, 3))
							line_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
					end
					5: begin
						line_q.push_back(CH_BSL);
						line_q.push_back(CH_LX);
						repeat ($urandom_range(1, 2))
							line_q.push_back(hex_char());
					end
					6: begin
						line_q.push_back(CH_BSL);
						line_q.push_back(8'($urandom_range(32, 126)));
					end
					7: line_q.push_back(8'($urandom));
					8: begin
						line_q.push_back(CH_BSL);
						line_q.push_back(8'($urandom));
					end
					default: begin
						line_q.push_back(CH_BSL);
						line_q.push_back(CH_LX);
						line_q.push_back(8'($urandom));
					end
				endcase
			end
			MODE_RAW: begin
				case (k)
					0: begin
						do c = 8'($urandom_range(33, 126)); while (c >= CH_0 && c <= CH_9);
						line_q.push_back(c);
					end
					1: line_q.push_back(CH_0);
					2: begin
						line_q.push_back(CH_0);
						line_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
						repeat (2) line_q.push_back(hex_char());
					end
					3: begin
						line_q.push_back(CH_0);
						repeat ($urandom_range(1, 3))
							line_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
					end
					4: begin
						line_q.push_back(CH_0);
						line_q.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
						repeat ($urandom_range(1, 8))
							line_q.push_back(CH_0 + 8'($urandom_range(0, 1)));
					end
					5, 6: begin
						line_q.push_back(CH_1 + 8'($urandom_range(0, 8)));
						repeat ($urandom_range(0, 2))
							line_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
					end
					7: line_q.push_back(8'($urandom));
					8: begin
						line_q.push_back(CH_0);
						line_q.push_back(CH_LX);
						line_q.push_back(8'($urandom));
					end
					default: begin
						line_q.push_back(CH_0);
						line_q.push_back(CH_LB);
						line_q.push_back(8'($urandom));
					end
				endcase
				line_q.push_back($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 32)) :
					CH_SPACE);
			end
			MODE_HEX: begin
				if (k < 8) begin
					repeat ($urandom_range(1, 2))
						line_q.push_back(hex_char());
					line_q.push_back($urandom_range(0, 4) == 0 ?
						8'($urandom_range(0, 32)) : CH_SPACE);
				end else begin
					line_q.push_back(8'($urandom));
				end
			end
			default: line_q.push_back(8'($urandom));
		endcase
	endtask

	initial begin
		mode_t order[8];
		mode_t m;
		logic [EOL_CNT_W-1:0] n;
		logic [CFG_W-1:0] w;
		int p;
		order = '{MODE_TEXT, MODE_RAW, MODE_TEXT, MODE_HEX, MODE_OFF, MODE_TEXT,
			MODE_RAW, MODE_HEX};
		decoded = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// text mode at reset values: octal, short hex, bad escapes, dangling backslash
		queue_text("\\101\\x7Z\\");
		line_q.push_back(8'hFF);
		line_q.push_back(8'h00);
		line_q.push_back(CH_BSL);
		send_line(1'b1);
		drain();

		// raw mode: overflowing decimal, 0b cut by line end, mode write drops a run
		set_config(MODE_RAW, 3'd0, '0);
		queue_text("999 0b");
		send_line(1'b1);
		queue_text("12");
		send_line(1'b0);
		drain();
		write_reg(REG_PARSE_MODE, CFG_W'(MODE_RAW));
		cfg_we <= 1'b0;
		send_char(8'($urandom), 1'b1);
		drain();

		// hex mode: full pair, then a single digit flushed at line end
		set_config(MODE_HEX, 3'd7, '1);
		queue_text("fF 7");
		send_line(1'b1);
		drain();

		items_sent = 0;
		p = 0;
		while ((p < 8 || items_sent < RANDOM_ITEMS) && p < 40) begin
			m = (p < 8) ? order[p] : mode_t'($urandom_range(0, 2));
			case (p)
				0: n = 3'd7;
				2: n = 3'd0;
				5: n = 3'd4;
				default: n = 3'($urandom_range(0, 7));
			endcase
			if (p == 0)
				w = '1;
			else if (p == 2)
				w = '0;
			else
				w = $urandom;
			if (p == 1)
				write_reg(REG_SPARE, $urandom);
			set_config(m, n, w);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 4))
					add_token(m);
				send_line(1'b1);
			end
			drain();
			p++;
		end

		repeat (2 * SETTLE) @(posedge clk);
		if (decoded.mismatch_count == 0 && decoded.waiting() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
